[hdl/throttle_to_velocity_supervisor_macros.svh]
// Assertion macros shared by the supervisor RTL.
// Every macro samples on the rising edge of clk and is quiet while rst is high.
`ifndef THROTTLE_TO_VELOCITY_SUPERVISOR_MACROS_SVH
`define THROTTLE_TO_VELOCITY_SUPERVISOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TTV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("supervisor check failed");
`define TTV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("supervisor check failed");
`define TTV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("supervisor check failed");
`else
`define TTV_ASSERT(lbl, prop)
`define TTV_ASSERT_IMPL(lbl, ante, cons)
`define TTV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/ttv_pkg.sv]
package ttv_pkg;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_STARTING,
    MODE_IDLE,
    MODE_RUNNING
  } ttv_mode_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_VEL,
    CMD_STATE
  } ttv_cmd_t;

  typedef enum logic [1:0] {
    REQ_IDLE,
    REQ_STARTUP,
    REQ_CLOSED
  } ttv_req_t;

  // arm switch codes
  localparam logic [1:0] SW_DISARMED = 2'd0;
  localparam logic [1:0] SW_ARM_A    = 2'd1;
  localparam logic [1:0] SW_ARM_B    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DEADBAND   = 3'd0;
  localparam logic [2:0] CFG_RUN_TICKS  = 3'd1;
  localparam logic [2:0] CFG_IDLE_TICKS = 3'd2;
  localparam logic [2:0] CFG_SS_RATE    = 3'd3;
  localparam logic [2:0] CFG_SS_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_HS_THRESH  = 3'd5;

  localparam logic signed [10:0] THR_MAX = 11'sd1000;
  localparam logic signed [10:0] THR_MIN = -11'sd1000;

  // x/10 for x <= 3000: (x * 6554) >> 16 is exact
  localparam logic [24:0] DIV10_RECIP = 25'd6554;
  localparam int          DIV10_SHIFT = 16;

  localparam logic [9:0] RATE_NORMAL_SLOW = 10'd50;
  localparam logic [9:0] RATE_NORMAL_FAST = 10'd200;
  localparam logic [9:0] RATE_HIGH_RISE   = 10'd150;
  localparam logic [9:0] RATE_HIGH_FALL   = 10'd200;

  localparam int RES_MAX = 3;

  typedef struct packed {
    logic               axis_idle;
    logic signed [10:0] throttle;
    logic [1:0]         sw_pos;
  } ttv_in_t;

  typedef struct packed {
    logic [7:0]  deadband_permille;
    logic [7:0]  run_ticks;
    logic [7:0]  idle_ticks;
    logic [9:0]  soft_start_rate;
    logic [12:0] soft_start_limit;
    logic [12:0] fast_thresh;
  } ttv_cfg_t;

  typedef struct packed {
    logic [1:0]         prev_switch;
    ttv_mode_t          mode;
    logic [7:0]         hold_count;
    logic signed [13:0] ramped_velocity;
  } ttv_state_t;

  typedef struct packed {
    ttv_cmd_t           command;
    ttv_req_t           requested_state;
    logic signed [13:0] velocity;
    logic               last;
  } ttv_result_t;

  function automatic ttv_result_t mk_result(ttv_cmd_t c, ttv_req_t r,
                                            logic signed [13:0] v);
    ttv_result_t res;
    res.command         = c;
    res.requested_state = r;
    res.velocity        = v;
    res.last            = 1'b0;
    return res;
  endfunction

endpackage

[hdl/ttv_step.sv]
module ttv_step (
  input  ttv_pkg::ttv_in_t                          item,
  input  ttv_pkg::ttv_cfg_t                         cfg,
  input  ttv_pkg::ttv_state_t                       cur,
  output ttv_pkg::ttv_state_t                       nxt,
  output ttv_pkg::ttv_result_t [ttv_pkg::RES_MAX-1:0] res,
  output logic [1:0]                                res_cnt
);

  logic               sw_edge, is_disarm, is_arm, in_start, go_on;
  ttv_pkg::ttv_mode_t mode1, mode2;
  logic [7:0]         hold1, hold2, hc, lim;

  logic signed [10:0] thr_c, thr_negd;
  logic               thr_neg;
  logic [9:0]         mag, athr, athr_eff;
  logic [11:0]        mag3, athr3;
  logic [24:0]        prod;
  logic               at_db, near_zero, cond_run, cond_idle, hys_fire;

  logic [12:0]        vmag;
  logic signed [13:0] vel, rv, rv_next;
  logic [13:0]        aprev;
  logic signed [14:0] diff;
  logic               ss_zone, high;
  logic [9:0]         rise, fall;
  logic [1:0]         k;

  assign sw_edge   = item.sw_pos != cur.prev_switch;
  assign is_disarm = sw_edge && (item.sw_pos == ttv_pkg::SW_DISARMED);
  assign is_arm    = sw_edge && (item.sw_pos == ttv_pkg::SW_ARM_A ||
                                 item.sw_pos == ttv_pkg::SW_ARM_B);
  assign in_start  = !sw_edge && (cur.mode == ttv_pkg::MODE_STARTING);
  assign go_on     = !is_arm && !(in_start && !item.axis_idle);

  // mode after the switch edge / startup check, hold cleared on a change
  always_comb begin
    mode1 = cur.mode;
    hold1 = cur.hold_count;
    priority if (is_disarm) begin
      mode1 = ttv_pkg::MODE_OFF;
    end else if (is_arm) begin
      mode1 = ttv_pkg::MODE_STARTING;
    end else if (in_start && item.axis_idle) begin
      mode1 = ttv_pkg::MODE_IDLE;
    end else begin
      mode1 = cur.mode;
    end
    if (mode1 != cur.mode) begin
      hold1 = '0;
    end
  end

  // clamp, then scale reverse by 3/10 toward zero
  always_comb begin
    thr_c = item.throttle;
    if (item.throttle > ttv_pkg::THR_MAX) begin
      thr_c = ttv_pkg::THR_MAX;
    end else if (item.throttle < ttv_pkg::THR_MIN) begin
      thr_c = ttv_pkg::THR_MIN;
    end
  end

  assign thr_neg  = thr_c[10];
  assign thr_negd = -thr_c;
  assign mag      = thr_neg ? thr_negd[9:0] : thr_c[9:0];
  assign mag3     = {1'b0, mag, 1'b0} + {2'b00, mag};
  assign prod     = {13'd0, mag3} * ttv_pkg::DIV10_RECIP;
  assign athr     = thr_neg ? {1'b0, prod[ttv_pkg::DIV10_SHIFT +: 9]} : mag;

  // |thr| < floor(db/3)  is the same as  3*|thr| + 3 <= db
  assign athr3     = {1'b0, athr, 1'b0} + {2'b00, athr};
  assign at_db     = athr >= {2'b00, cfg.deadband_permille};
  assign near_zero = (athr3 + 12'd3) <= {4'd0, cfg.deadband_permille};
  assign cond_run  = go_on && (mode1 == ttv_pkg::MODE_IDLE) && at_db;
  assign cond_idle = go_on && (mode1 == ttv_pkg::MODE_RUNNING) && near_zero;
  assign hc        = (hold1 == 8'hFF) ? hold1 : hold1 + 8'd1;
  assign lim       = cond_run ? cfg.run_ticks : cfg.idle_ticks;
  // hc is at least one, so a zero tick count acts like one
  assign hys_fire  = (cond_run || cond_idle) && (hc >= lim);

  // next mode and hold count
  always_comb begin
    mode2 = mode1;
    hold2 = hold1;
    if (go_on) begin
      if (hys_fire) begin
        mode2 = cond_run ? ttv_pkg::MODE_RUNNING : ttv_pkg::MODE_IDLE;
        hold2 = '0;
      end else if (cond_run || cond_idle) begin
        hold2 = hc;
      end else begin
        hold2 = '0;
      end
    end
  end

  // setpoint and staged rate limiter
  assign athr_eff = at_db ? athr : '0;
  assign vmag     = {1'b0, athr_eff, 2'b00} + {3'd0, athr_eff};
  assign vel      = thr_neg ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
  assign rv       = cur.ramped_velocity;
  assign aprev    = rv[13] ? 14'(-rv) : 14'(rv);
  assign diff     = 15'(vel) - 15'(rv);
  assign ss_zone  = (aprev < {1'b0, cfg.soft_start_limit}) && ({1'b0, vmag} > aprev);
  assign high     = aprev > {1'b0, cfg.fast_thresh};

  always_comb begin
    priority if (ss_zone) begin
      rise = cfg.soft_start_rate;
      fall = cfg.soft_start_rate;
    end else if (high) begin
      rise = ttv_pkg::RATE_HIGH_RISE;
      fall = ttv_pkg::RATE_HIGH_FALL;
    end else if (!rv[13]) begin
      rise = ttv_pkg::RATE_NORMAL_SLOW;
      fall = ttv_pkg::RATE_NORMAL_FAST;
    end else begin
      rise = ttv_pkg::RATE_NORMAL_FAST;
      fall = ttv_pkg::RATE_NORMAL_SLOW;
    end
  end

  always_comb begin
    priority if (diff > $signed({5'd0, rise})) begin
      rv_next = rv + $signed({4'd0, rise});
    end else if (diff < -$signed({5'd0, fall})) begin
      rv_next = rv - $signed({4'd0, fall});
    end else begin
      rv_next = vel;
    end
  end

  always_comb begin
    nxt.prev_switch     = item.sw_pos;
    nxt.mode            = mode2;
    nxt.hold_count      = hold2;
    nxt.ramped_velocity = go_on ? rv_next : rv;
  end

  // result list of the tick, in order
  always_comb begin
    res = '0;
    k   = '0;
    if (is_arm) begin
      res[0] = ttv_pkg::mk_result(ttv_pkg::CMD_CLEAR, ttv_pkg::REQ_IDLE, '0);
      res[1] = ttv_pkg::mk_result(ttv_pkg::CMD_VEL, ttv_pkg::REQ_IDLE, '0);
      res[2] = ttv_pkg::mk_result(ttv_pkg::CMD_STATE, ttv_pkg::REQ_STARTUP, '0);
      k      = 2'd3;
    end else begin
      if (is_disarm) begin
        res[k] = ttv_pkg::mk_result(ttv_pkg::CMD_STATE, ttv_pkg::REQ_IDLE, '0);
        k      = k + 2'd1;
      end else if (in_start) begin
        res[k] = ttv_pkg::mk_result(ttv_pkg::CMD_VEL, ttv_pkg::REQ_IDLE, '0);
        k      = k + 2'd1;
      end
      if (hys_fire) begin
        res[k] = ttv_pkg::mk_result(ttv_pkg::CMD_STATE,
                   cond_run ? ttv_pkg::REQ_CLOSED : ttv_pkg::REQ_IDLE, '0);
        k      = k + 2'd1;
      end
      if (go_on) begin
        res[k] = ttv_pkg::mk_result(ttv_pkg::CMD_VEL, ttv_pkg::REQ_IDLE, rv_next);
        k      = k + 2'd1;
      end
    end
    res[k - 2'd1].last = 1'b1;
  end

  assign res_cnt = k;

endmodule

[hdl/ttv_resq.sv]
`include "throttle_to_velocity_supervisor_macros.svh"

module ttv_resq (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  ttv_pkg::ttv_result_t [ttv_pkg::RES_MAX-1:0] load_res,
  input  logic [1:0]                                load_cnt,
  output logic                                      free,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [15:0]                               m_tdata,
  output logic                                      m_tlast,
  output logic [1:0]                                m_tuser
);

  ttv_pkg::ttv_result_t [ttv_pkg::RES_MAX-1:0] ents;
  logic [1:0]           cnt, idx, cnt_m1;
  logic                 busy, take, take_last;
  ttv_pkg::ttv_result_t cur;

  assign cnt_m1    = cnt - 2'd1;
  assign take      = busy && m_tready;
  assign take_last = take && (idx == cnt_m1);
  assign free      = !busy || take_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take_last) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= load_res;
      cnt  <= load_cnt;
    end
  end

  assign cur      = ents[idx];
  assign m_tvalid = busy;
  assign m_tdata  = {cur.velocity, cur.requested_state};
  assign m_tuser  = cur.command;
  assign m_tlast  = cur.last;

  `TTV_ASSERT_IMPL(a_load_free, load, free)
  `TTV_ASSERT_IMPL(a_idx_range, m_tvalid, idx < cnt)
  `TTV_ASSERT_IMPL(a_last_flag, m_tvalid, m_tlast == (idx == cnt_m1))
  `TTV_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(idx))

endmodule

[hdl/throttle_to_velocity_supervisor.sv]
// Throttle-to-velocity supervisor for one motor axis.
// Slave channel: one request per control tick carrying the switch position,
// the signed throttle in permille and the axis-idle report. Master channel:
// the commands of that tick, one to three, with the kind in m_tuser (clear
// errors, set velocity, set axis state) and the final one marked by m_tlast.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 deadband,
// 1 run ticks, 2 idle ticks, 3 soft-start rate, 4 soft-start limit, 5
// high-speed threshold); other indexes are dropped. Write only while idle.
// Flow: a request accepted on the slave port lands in the input register; its
// commands are computed from it and loaded into the result buffer once the
// buffer is free, and the first command is offered from then on.
// Throughput: one tick per cycle when it yields one command and m_tready stays
// high; a tick with several commands holds the result buffer until its last
// command is taken, since the master port moves one command per cycle at most.
// Reset (rst, synchronous): registers take their defaults, switch history,
// mode, hold count and ramp clear, both channels go empty.
// Stall: with m_tready low the current command holds, the input register
// holds one more tick and s_tready drops until the buffer drains.
`include "throttle_to_velocity_supervisor_macros.svh"

module throttle_to_velocity_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] sw_pos, [12:2] throttle, [13] axis_idle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] requested_state, [15:2] velocity
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [1:0] command
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  ttv_pkg::ttv_cfg_t    cfg;
  ttv_pkg::ttv_state_t  st, st_next;
  ttv_pkg::ttv_in_t     in_item;
  logic                 in_valid, advance, q_free;
  ttv_pkg::ttv_result_t [ttv_pkg::RES_MAX-1:0] step_res;
  logic [1:0]           step_cnt;

  // input register: take a request whenever it is empty or moving on
  assign advance  = in_valid && q_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= ttv_pkg::ttv_in_t'(s_tdata[13:0]);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_permille <= 8'd25;
      cfg.run_ticks         <= 8'd4;
      cfg.idle_ticks        <= 8'd10;
      cfg.soft_start_rate   <= 10'd10;
      cfg.soft_start_limit  <= 13'd200;
      cfg.fast_thresh       <= 13'd1500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttv_pkg::CFG_DEADBAND:   cfg.deadband_permille <= cfg_wdata[7:0];
        ttv_pkg::CFG_RUN_TICKS:  cfg.run_ticks         <= cfg_wdata[7:0];
        ttv_pkg::CFG_IDLE_TICKS: cfg.idle_ticks        <= cfg_wdata[7:0];
        ttv_pkg::CFG_SS_RATE:    cfg.soft_start_rate   <= cfg_wdata[9:0];
        ttv_pkg::CFG_SS_LIMIT:   cfg.soft_start_limit  <= cfg_wdata;
        ttv_pkg::CFG_HS_THRESH:  cfg.fast_thresh       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // supervisor state advances once per tick, as the tick's commands load
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_switch     <= ttv_pkg::SW_DISARMED;
      st.mode            <= ttv_pkg::MODE_OFF;
      st.hold_count      <= '0;
      st.ramped_velocity <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  ttv_step u_step (
    .item    (in_item),
    .cfg     (cfg),
    .cur     (st),
    .nxt     (st_next),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  ttv_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .load_res (step_res),
    .load_cnt (step_cnt),
    .free     (q_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  `TTV_ASSERT(a_ramp_range, st.ramped_velocity >= -14'sd1500 && st.ramped_velocity <= 14'sd5000)
  `TTV_ASSERT_IMPL(a_hold_clear, st.mode < ttv_pkg::MODE_IDLE, st.hold_count == 8'd0)
  `TTV_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_item))

endmodule
